// ===== design/rlee_pkg.sv =====
// Shared types and constants for the escaped run-length encoder.
// Holds the flush-command record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package rlee_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 4;
  localparam int unsigned IdxW = 1;
  localparam int unsigned QueueDepth = 4;

  localparam logic [LenW-1:0] RunCap = 4'd9;
  localparam logic [LenW-1:0] MinRunCap = 4'd4;
  localparam logic [ByteW-1:0] DigitBase = 8'h30;
  localparam logic [ByteW-1:0] EscapeReset = 8'h2a;
  localparam logic [LenW-1:0] MinRunReset = 4'd4;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] RegEscape = 1'b0;
  localparam logic [IdxW-1:0] RegMinRun = 1'b1;

  // One finished run: either compressed (byte, escape, digit) or raw (len copies).
  typedef struct packed {
    logic             comp;
    logic [ByteW-1:0] run_byte;
    logic [LenW-1:0]  run_len;
  } flush_t;

  // Everything one input item causes: one or two run flushes.
  typedef struct packed {
    flush_t first;
    logic   second_valid;
    flush_t second;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/rlee_front.sv =====
// Front end of the escaped run-length encoder: run tracking and flush classification.
// Depends on rlee_pkg.
`default_nettype none

module rlee_front
  import rlee_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             final_byte_i,
  input  logic [ByteW-1:0] escape_i,
  input  logic [LenW-1:0]  min_run_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o
);

  logic [ByteW-1:0] run_byte_q, run_byte_d;
  logic [LenW-1:0]  run_len_q, run_len_d;
  logic [LenW-1:0]  min_eff;
  logic             extend;
  logic             flush_old, flush_new;
  logic [LenW-1:0]  grown_len;
  flush_t           old_run, new_run;

  assign min_eff = (min_run_i > MinRunCap) ? MinRunCap : min_run_i;
  assign extend = (run_len_q != '0) && (data_byte_i == run_byte_q) && (run_len_q < RunCap);
  assign flush_old = !extend && (run_len_q != '0);
  assign grown_len = extend ? (run_len_q + 4'd1) : 4'd1;
  assign flush_new = (grown_len >= RunCap) || final_byte_i;

  always_comb begin
    old_run.run_byte = run_byte_q;
    old_run.run_len = run_len_q;
    old_run.comp = (run_byte_q == escape_i) || (run_len_q >= min_eff);
    new_run.run_byte = data_byte_i;
    new_run.run_len = grown_len;
    new_run.comp = (data_byte_i == escape_i) || (grown_len >= min_eff);
  end

  always_comb begin
    cmd_o.first = flush_old ? old_run : new_run;
    cmd_o.second = new_run;
    cmd_o.second_valid = flush_old && flush_new;
    cmd_valid_o = accept_i && (flush_old || flush_new);
  end

  always_comb begin
    run_byte_d = run_byte_q;
    run_len_d = run_len_q;
    if (accept_i) begin
      run_byte_d = data_byte_i;
      run_len_d = flush_new ? '0 : grown_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_byte_q <= '0;
      run_len_q <= '0;
    end else begin
      run_byte_q <= run_byte_d;
      run_len_q <= run_len_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rlee_cmd_fifo.sv =====
// Small command queue between the front and back ends of the encoder.
// Depends on rlee_pkg for the command record.
`default_nettype none

module rlee_cmd_fifo
  import rlee_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("command queue count overflow");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full command queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

// ===== design/rlee_back.sv =====
// Back end of the escaped run-length encoder: expands flush commands into bytes.
// Depends on rlee_pkg; holds the output register of the top level.
`default_nettype none

module rlee_back
  import rlee_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic [ByteW-1:0] escape_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_of_burst_o
);

  logic             sel_q, sel_d;
  logic [1:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;
  flush_t           cur;
  logic [ByteW-1:0] cur_byte;
  logic             run_done, cmd_done, advance, taken;

  assign cur = sel_q ? cmd_i.second : cmd_i.first;
  assign taken = pop_i && out_valid_q;
  assign advance = cmd_valid_i && (!out_valid_q || taken);

  always_comb begin
    if (cur.comp) begin
      unique case (idx_q)
        2'd0: cur_byte = cur.run_byte;
        2'd1: cur_byte = escape_i;
        default: cur_byte = DigitBase + {4'b0, cur.run_len};
      endcase
      run_done = (idx_q == 2'd2);
    end else begin
      cur_byte = cur.run_byte;
      run_done = ({2'b0, idx_q} + 4'd1) == cur.run_len;
    end
  end

  assign cmd_done = run_done && (sel_q || !cmd_i.second_valid);
  assign cmd_pop_o = advance && cmd_done;

  always_comb begin
    sel_d = sel_q;
    idx_d = idx_q;
    out_valid_d = out_valid_q;
    if (taken) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      if (run_done) begin
        idx_d = '0;
        sel_d = !cmd_done;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= cur_byte;
      out_last_q <= cmd_done;
    end
  end

  assign empty_o = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_of_burst_o = out_last_q;

endmodule

`default_nettype wire

// ===== design/run_length_encoder_escaped_unit.sv =====
// Top level of the escaped run-length encoder with configuration registers.
// Depends on rlee_pkg, rlee_front, rlee_cmd_fifo and rlee_back.
//
// Usage: raw bytes enter through a queue-style port (push/full) with a
// final_byte flag on the last byte of a stream. Encoded bytes leave through
// a queue-style port (empty/pop); last_of_burst marks the final byte that
// one input transaction caused. An input transaction that ends no run gives
// no output at all.
// The front end tracks the open run and, per input transaction, produces
// zero, one or two run flushes, already classified as compressed or raw.
// These travel through a small command queue to the back end, which emits
// one byte per cycle into a single output register while the receiver
// keeps popping. The first byte of a transaction passes through the command
// queue and then the output register before it reaches the result ports.
// Input is accepted every cycle until the command queue fills; a flush
// expands into at most three bytes, and a transaction that closes two runs
// into at most six. When the receiver stalls, the output register holds
// its byte, the back end waits, the queue fills and full rises. Reset
// empties the queue and the output register, closes the open run and
// restores escape_char to '*' and min_run to 4. The user must see that
// configuration is written only while idle; the block does not enforce it.
`default_nettype none

module run_length_encoder_escaped_unit
  import rlee_pkg::*;
#(
  parameter int unsigned FifoDepth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [ByteW-1:0] cfg_data_i,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             final_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_of_burst_o
);

  logic [ByteW-1:0] escape_q;
  logic [LenW-1:0]  min_run_q;
  logic             accept;
  logic             cmd_push, cmd_pop, cmd_empty;
  cmd_t             cmd_in, cmd_head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= EscapeReset;
      min_run_q <= MinRunReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegEscape: escape_q <= cfg_data_i;
        RegMinRun: min_run_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  rlee_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .escape_i     (escape_q),
    .min_run_i    (min_run_q),
    .cmd_valid_o  (cmd_push),
    .cmd_o        (cmd_in)
  );

  rlee_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  rlee_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (!cmd_empty),
    .cmd_i           (cmd_head),
    .cmd_pop_o       (cmd_pop),
    .escape_i        (escape_q),
    .pop_i           (pop),
    .empty_o         (empty),
    .out_byte_o      (out_byte_o),
    .last_of_burst_o (last_of_burst_o)
  );

endmodule

`default_nettype wire
